// ===== hw/rtl/bmh_pkg.sv =====
// shared constants, types and helpers of the binary max-heap
package bmh_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 16;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int TOP_LEVEL  = COUNT_BITS - 1;
    localparam int NUM_LEVELS = TOP_LEVEL + 1;
    localparam int LVL_BITS   = $clog2(NUM_LEVELS);
    localparam int ROW_BITS   = (TOP_LEVEL > 1) ? TOP_LEVEL - 1 : 1;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_INS = 2'd0,
        OP_REM = 2'd1,
        OP_PUT = 2'd2
    } t_op;

    // request walking down the level chain
    typedef struct packed {
        logic                  valid;
        t_op                   op;
        logic [COUNT_BITS-1:0] pos;
        logic [VALUE_BITS-1:0] carry;
        logic [COUNT_BITS-1:0] last;
        logic [LVL_BITS-1:0]   tlev;
    } t_tok;

    // write handed up to the level above
    typedef struct packed {
        logic                  we;
        logic [COUNT_BITS-1:0] pos;
        logic [VALUE_BITS-1:0] value;
    } t_wb;

    // broadcast read of one heap position
    typedef struct packed {
        logic                  valid;
        logic [LVL_BITS-1:0]   lev;
        logic [COUNT_BITS-1:0] pos;
    } t_fetch;

    // port bundle of one level memory (rows hold sibling pairs)
    typedef struct packed {
        logic [ROW_BITS-1:0]              rd_addr;
        logic [ROW_BITS-1:0]              wr_addr;
        logic [1:0]                       wr_en;
        logic [1:0][VALUE_BITS-1:0]       wr_data;
    } t_ram_req;

    function automatic logic [LVL_BITS-1:0] floor_log2(input logic [COUNT_BITS-1:0] v);
        logic [LVL_BITS-1:0] r;
        r = '0;
        for (int k = 0; k < COUNT_BITS; k++) begin
            if (v[k]) begin
                r = LVL_BITS'(k);
            end
        end
        return r;
    endfunction

    function automatic int level_rows(input int lvl);
        int full;
        int tail;
        full = (lvl == 0) ? 1 : (1 << (lvl - 1));
        tail = ((CAPACITY - (1 << lvl)) >> 1) + 1;
        return (tail < full) ? tail : full;
    endfunction

endpackage

// ===== hw/rtl/bmh_ram.sv =====
// generic lane-writable memory with one write and one registered read port
module bmh_ram #(
    parameter int DEPTH     = 2,
    parameter int LANES     = 2,
    parameter int LANE_BITS = 16,
    parameter int ADDR_BITS = 1
) (
    input  logic                            i_clk,
    input  logic [LANES-1:0]                i_wr_en,
    input  logic [ADDR_BITS-1:0]            i_wr_addr,
    input  logic [LANES-1:0][LANE_BITS-1:0] i_wr_data,
    input  logic [ADDR_BITS-1:0]            i_rd_addr,
    output logic [LANES-1:0][LANE_BITS-1:0] o_rd_data
);

    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LANES-1:0][LANE_BITS-1:0] r_mem [DEPTH];
    logic [LANES-1:0][LANE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_wr_en[l]) begin
                r_mem[i_wr_addr[IDX_BITS-1:0]][l] <= i_wr_data[l];
            end
        end
        r_rd_data <= r_mem[i_rd_addr[IDX_BITS-1:0]];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/bmh_cell.sv =====
// one heap level: drives the ports of its level memory, steps a request and hands it down
module bmh_cell import bmh_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [LVL_BITS-1:0]        i_level,
    input  t_tok                       i_tok,
    output t_tok                       o_tok,
    input  t_wb                        i_wb,
    output t_wb                        o_wb,
    input  t_fetch                     i_fetch,
    output logic [VALUE_BITS-1:0]      o_fetch_data,
    output logic                       o_done,
    output t_ram_req                   o_ram,
    input  logic [1:0][VALUE_BITS-1:0] i_ram_rdata
);

    logic [ROW_BITS:0]     w_one_hot;
    logic [ROW_BITS-1:0]   w_mask;
    logic                  w_imm;
    logic                  w_go;
    logic                  r_busy;
    t_tok                  r_tok;
    t_tok                  r_out;
    t_tok                  n_out;
    logic                  r_fetch_hit;
    logic                  r_fetch_side;
    logic [VALUE_BITS-1:0] w_lo;
    logic [VALUE_BITS-1:0] w_hi;
    logic [VALUE_BITS-1:0] w_stored;
    logic [LVL_BITS-1:0]   w_sh;
    logic [COUNT_BITS:0]   w_c;
    logic                  w_right_ok;
    logic                  w_pick_r;
    logic [VALUE_BITS-1:0] w_child_v;
    logic [COUNT_BITS-1:0] w_cpos;
    logic                  w_deeper;
    logic                  w_own_we;
    logic [COUNT_BITS-1:0] w_own_pos;
    logic [VALUE_BITS-1:0] w_own_val;
    logic                  w_wr_we;
    logic [COUNT_BITS-1:0] w_wr_pos;
    logic [VALUE_BITS-1:0] w_wr_val;
    logic                  w_wr_side;

    function automatic logic [ROW_BITS-1:0] row_of(input logic [COUNT_BITS-1:0] p,
                                                   input logic [ROW_BITS-1:0] m);
        return ROW_BITS'(p >> 1) & m;
    endfunction

    // row index mask of this level (rows hold sibling pairs)
    assign w_one_hot = {{ROW_BITS{1'b0}}, 1'b1} << (i_level - LVL_BITS'(1));
    assign w_mask    = (i_level == '0) ? '0 : ROW_BITS'(w_one_hot - {{ROW_BITS{1'b0}}, 1'b1});

    assign w_imm = i_tok.valid && ((i_tok.op == OP_PUT) ||
                                   ((i_tok.op == OP_INS) && (i_tok.pos == i_tok.last)));
    assign w_go  = i_tok.valid && !w_imm;

    assign w_lo       = i_ram_rdata[0];
    assign w_hi       = i_ram_rdata[1];
    assign w_stored   = ((i_level != '0) && r_tok.pos[0]) ? w_hi : w_lo;
    assign w_sh       = r_tok.tlev - i_level - LVL_BITS'(1);
    assign w_c        = {r_tok.pos, 1'b0};
    assign w_right_ok = w_c < {1'b0, r_tok.last};
    assign w_pick_r   = w_right_ok && (w_hi > w_lo);
    assign w_child_v  = w_pick_r ? w_hi : w_lo;
    assign w_cpos     = w_c[COUNT_BITS-1:0] | {{(COUNT_BITS-1){1'b0}}, w_pick_r};
    assign w_deeper   = {w_cpos, 1'b0} <= {1'b0, r_tok.last};

    always_comb begin
        n_out     = '0;
        o_wb      = '0;
        o_done    = 1'b0;
        w_own_we  = 1'b0;
        w_own_pos = i_tok.pos;
        w_own_val = i_tok.carry;
        if (w_imm) begin
            w_own_we = 1'b1;
            o_done   = 1'b1;
        end
        if (r_busy) begin
            unique case (r_tok.op)
                OP_INS: begin
                    // larger carry takes the slot, the old value moves on
                    n_out     = r_tok;
                    n_out.pos = r_tok.last >> w_sh;
                    if (w_stored < r_tok.carry) begin
                        w_own_we    = 1'b1;
                        w_own_pos   = r_tok.pos;
                        w_own_val   = r_tok.carry;
                        n_out.carry = w_stored;
                    end
                end
                OP_REM: begin
                    if (r_tok.carry < w_child_v) begin
                        o_wb = '{we: 1'b1, pos: r_tok.pos, value: w_child_v};
                        if (w_deeper) begin
                            n_out     = r_tok;
                            n_out.pos = w_cpos;
                        end else begin
                            w_own_we  = 1'b1;
                            w_own_pos = w_cpos;
                            w_own_val = r_tok.carry;
                            o_done    = 1'b1;
                        end
                    end else begin
                        o_wb   = '{we: 1'b1, pos: r_tok.pos, value: r_tok.carry};
                        o_done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // write port: hand-up from the level below or this level's own write
    always_comb begin
        w_wr_we  = w_own_we;
        w_wr_pos = w_own_pos;
        w_wr_val = w_own_val;
        if (i_wb.we) begin
            w_wr_we  = 1'b1;
            w_wr_pos = i_wb.pos;
            w_wr_val = i_wb.value;
        end
    end

    assign w_wr_side     = (i_level != '0) && w_wr_pos[0];
    assign o_ram.wr_addr = row_of(w_wr_pos, w_mask);
    assign o_ram.wr_en   = w_wr_we ? (w_wr_side ? 2'b10 : 2'b01) : 2'b00;
    assign o_ram.wr_data = {w_wr_val, w_wr_val};
    assign o_ram.rd_addr = i_fetch.valid ? row_of(i_fetch.pos, w_mask) :
                           (i_tok.op == OP_REM) ? (ROW_BITS'(i_tok.pos) & w_mask) :
                           row_of(i_tok.pos, w_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out       <= '0;
            r_fetch_hit <= 1'b0;
        end else begin
            r_busy      <= w_go;
            r_out       <= n_out;
            r_fetch_hit <= i_fetch.valid && (i_fetch.lev == i_level);
        end
        if (w_go) begin
            r_tok <= i_tok;
        end
        r_fetch_side <= (i_level != '0) && i_fetch.pos[0];
    end

    assign o_tok        = r_out;
    assign o_fetch_data = r_fetch_hit ? (r_fetch_side ? w_hi : w_lo) : '0;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok.valid |-> !r_busy)
        else $error("request reached a level that is still working");

endmodule

// ===== hw/rtl/binary_max_heap.sv =====
// binary max-heap priority queue: a chain of level cells, one level memory each
// operation: insert walks from the root down to level d = floor(log2(count after)) before the strobe;
//   remove fetches the root, fetches the last element and loads, then walks the levels;
//   status errors are reported without a walk; one request at a time (busy until the strobe)
// each level does one registered memory read, then a compare and write
// reset: i_rst_n low at a clock edge empties the heap and drops any open request;
//   heap contents are not cleared; the result strobe cannot be stalled by the receiver
module binary_max_heap import bmh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_kind,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_strobe,
    output logic [VALUE_BITS-1:0] o_removed_value,
    output logic [1:0]            o_status,
    output logic [COUNT_BITS-1:0] o_count
);

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_FETCH_ROOT = 5'b00010,
        S_FETCH_LAST = 5'b00100,
        S_LOAD       = 5'b01000,
        S_RUN        = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    logic [COUNT_BITS-1:0]   r_elem, n_elem;
    logic                    r_kind, n_kind;
    logic [VALUE_BITS-1:0]   r_top, n_top;
    t_tok                    r_inj, n_inj;
    logic                    r_inj_deep, n_inj_deep;
    logic                    r_strobe, n_strobe;
    logic [VALUE_BITS-1:0]   r_res_removed, n_res_removed;
    logic [1:0]              r_res_status, n_res_status;
    logic [COUNT_BITS-1:0]   r_res_count, n_res_count;

    logic [COUNT_BITS-1:0]   w_elem_inc;
    logic [COUNT_BITS-1:0]   w_elem_dec;
    t_fetch                  w_fetch;
    logic [VALUE_BITS-1:0]   w_fetch_data;
    logic [NUM_LEVELS-1:0]   w_done;

    // chain wiring between neighboring level cells
    t_tok                    w_tok_in  [NUM_LEVELS];
    t_tok                    w_tok_out [NUM_LEVELS];
    t_wb                     w_wb_in   [NUM_LEVELS];
    t_wb                     w_wb_out  [NUM_LEVELS];
    t_ram_req                w_ram     [NUM_LEVELS];
    logic [1:0][VALUE_BITS-1:0] w_rdata [NUM_LEVELS];
    logic [VALUE_BITS-1:0]   w_fetch_rd [NUM_LEVELS];

    assign w_elem_inc = r_elem + COUNT_BITS'(1);
    assign w_elem_dec = r_elem - COUNT_BITS'(1);

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
        // insert requests and the root rewrite enter at the root cell,
        // a sift-down starts at level one where the root's children live
        if (g == 0) begin : g_head
            assign w_tok_in[g] = r_inj_deep ? '0 : r_inj;
        end else if (g == 1) begin : g_second
            assign w_tok_in[g] = w_tok_out[0].valid ? w_tok_out[0] :
                                 (r_inj_deep ? r_inj : '0);
        end else begin : g_rest
            assign w_tok_in[g] = w_tok_out[g-1];
        end

        if (g == NUM_LEVELS - 1) begin : g_tail
            assign w_wb_in[g] = '0;
        end else begin : g_body
            assign w_wb_in[g] = w_wb_out[g+1];
        end

        bmh_ram #(
            .DEPTH     (level_rows(g)),
            .LANES     (2),
            .LANE_BITS (VALUE_BITS),
            .ADDR_BITS (ROW_BITS)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (w_ram[g].wr_en),
            .i_wr_addr (w_ram[g].wr_addr),
            .i_wr_data (w_ram[g].wr_data),
            .i_rd_addr (w_ram[g].rd_addr),
            .o_rd_data (w_rdata[g])
        );

        bmh_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_level      (LVL_BITS'(g)),
            .i_tok        (w_tok_in[g]),
            .o_tok        (w_tok_out[g]),
            .i_wb         (w_wb_in[g]),
            .o_wb         (w_wb_out[g]),
            .i_fetch      (w_fetch),
            .o_fetch_data (w_fetch_rd[g]),
            .o_done       (w_done[g]),
            .o_ram        (w_ram[g]),
            .i_ram_rdata  (w_rdata[g])
        );
    end

    // only the addressed level answers a fetch, the rest drive zero
    always_comb begin
        w_fetch_data = '0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            w_fetch_data = w_fetch_data | w_fetch_rd[k];
        end
    end

    // request sequencer
    always_comb begin
        n_state       = r_state;
        n_elem        = r_elem;
        n_kind        = r_kind;
        n_top         = r_top;
        n_inj         = '0;
        n_inj_deep    = 1'b0;
        n_strobe      = 1'b0;
        n_res_removed = r_res_removed;
        n_res_status  = r_res_status;
        n_res_count   = r_res_count;
        w_fetch       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = i_kind;
                    if (i_kind == KIND_REMOVE) begin
                        if (r_elem == '0) begin
                            // remove on empty heap
                            n_strobe      = 1'b1;
                            n_res_removed = '0;
                            n_res_status  = ST_EMPTY;
                            n_res_count   = r_elem;
                        end else begin
                            n_state = S_FETCH_ROOT;
                        end
                    end else begin
                        if (r_elem == COUNT_BITS'(CAPACITY)) begin
                            // insert on full heap
                            n_strobe      = 1'b1;
                            n_res_removed = '0;
                            n_res_status  = ST_FULL;
                            n_res_count   = r_elem;
                        end else begin
                            // walk the root-to-new-slot path top down
                            n_elem  = w_elem_inc;
                            n_inj   = '{valid: 1'b1, op: OP_INS, pos: COUNT_BITS'(1),
                                        carry: i_value, last: w_elem_inc,
                                        tlev: floor_log2(w_elem_inc)};
                            n_state = S_RUN;
                        end
                    end
                end
            end
            S_FETCH_ROOT: begin
                w_fetch = '{valid: 1'b1, lev: '0, pos: COUNT_BITS'(1)};
                n_state = S_FETCH_LAST;
            end
            S_FETCH_LAST: begin
                w_fetch = '{valid: 1'b1, lev: floor_log2(r_elem), pos: r_elem};
                n_top   = w_fetch_data;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // last element is on the fetch bus now
                n_elem = w_elem_dec;
                if (r_elem == COUNT_BITS'(1)) begin
                    n_strobe      = 1'b1;
                    n_res_removed = r_top;
                    n_res_status  = ST_OK;
                    n_res_count   = w_elem_dec;
                    n_state       = S_IDLE;
                end else if (r_elem == COUNT_BITS'(2)) begin
                    // single survivor goes straight to the root
                    n_inj   = '{valid: 1'b1, op: OP_PUT, pos: COUNT_BITS'(1),
                                carry: w_fetch_data, last: w_elem_dec, tlev: '0};
                    n_state = S_RUN;
                end else begin
                    n_inj      = '{valid: 1'b1, op: OP_REM, pos: COUNT_BITS'(1),
                                   carry: w_fetch_data, last: w_elem_dec, tlev: '0};
                    n_inj_deep = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (|w_done) begin
                    n_strobe      = 1'b1;
                    n_res_removed = (r_kind == KIND_REMOVE) ? r_top : '0;
                    n_res_status  = ST_OK;
                    n_res_count   = r_elem;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_elem     <= '0;
            r_inj      <= '0;
            r_inj_deep <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_elem     <= n_elem;
            r_inj      <= n_inj;
            r_inj_deep <= n_inj_deep;
            r_strobe   <= n_strobe;
        end
        r_kind        <= n_kind;
        r_top         <= n_top;
        r_res_removed <= n_res_removed;
        r_res_status  <= n_res_status;
        r_res_count   <= n_res_count;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_removed_value = r_res_removed;
    assign o_status        = r_res_status;
    assign o_count         = r_res_count;

    // the deepest level never has a level below it to hand a request to
    a_tail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tok_out[NUM_LEVELS-1].valid)
        else $error("request handed past the deepest level");

    // the root level never hands a write further up
    a_root_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_wb_out[0].we)
        else $error("write handed above the root level");

    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_done))
        else $error("more than one level finished a request");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted request neither started nor reported");

endmodule

// ===== tb/binary_max_heap_tb.sv =====
// self-checking testbench of the binary max-heap priority queue
`timescale 1ns / 100ps

module binary_max_heap_tb import bmh_pkg::*;;

    // one result as it leaves the block
    typedef struct {
        logic [VALUE_BITS-1:0] removed_value;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] count;
    } t_heap_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_kind;
    logic [VALUE_BITS-1:0] i_value;
    logic                  o_strobe;
    logic [VALUE_BITS-1:0] o_removed_value;
    logic [1:0]            o_status;
    logic [COUNT_BITS-1:0] o_count;

    // own copy of the heap, 1-based positions, root at 1
    logic [VALUE_BITS-1:0] heap_mirror [1:CAPACITY];
    int                    mirror_count;

    // results still owed by the block, oldest first
    t_heap_result pending_results [$];
    int           error_count;
    // chance in percent that the sender pauses after a request
    int           sender_idle_pct;

    binary_max_heap u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_count         (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous ceiling: about a thousand requests, each with its walk plus any sender gaps
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // apply one request to the mirror and return what the block should report
    function automatic t_heap_result heap_apply(input logic kind,
                                                input logic [VALUE_BITS-1:0] value);
        t_heap_result          res;
        logic [VALUE_BITS-1:0] last;
        int                    pos;
        int                    child;
        int                    remaining;
        res.removed_value = '0;
        res.status        = ST_OK;
        if (kind == KIND_REMOVE) begin
            if (mirror_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed_value = heap_mirror[1];
                last              = heap_mirror[mirror_count];
                remaining         = mirror_count - 1;
                mirror_count      = remaining;
                pos               = 1;
                // sift down toward the larger child, left on a tie, stop on equal
                while (2 * pos <= remaining) begin
                    child = 2 * pos;
                    if (child < remaining && heap_mirror[child + 1] > heap_mirror[child]) begin
                        child++;
                    end
                    if (last < heap_mirror[child]) begin
                        heap_mirror[pos] = heap_mirror[child];
                        pos              = child;
                    end else begin
                        break;
                    end
                end
                heap_mirror[pos] = last;
            end
        end else begin
            if (mirror_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                mirror_count++;
                pos = mirror_count;
                // sift up while the parent is strictly smaller
                while (pos > 1 && heap_mirror[pos / 2] < value) begin
                    heap_mirror[pos] = heap_mirror[pos / 2];
                    pos              = pos / 2;
                end
                heap_mirror[pos] = value;
            end
        end
        res.count = COUNT_BITS'(mirror_count);
        return res;
    endfunction

    // called at a falling edge; returns at a falling edge with start possibly still high
    task automatic send_request(input logic kind, input logic [VALUE_BITS-1:0] value);
        start   = 1'b1;
        i_kind  = kind;
        i_value = value;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        pending_results.push_back(heap_apply(kind, value));
        @(negedge i_clk);
        if ($urandom_range(99) < sender_idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    endtask

    // every strobe is one result; compare it with the oldest expectation
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: removed_value %0d status %0d count %0d",
                       o_removed_value, o_status, o_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_removed_value !== want.removed_value) begin
                    $error("removed_value: expected %0d, actual %0d",
                           want.removed_value, o_removed_value);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    error_count++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, o_count);
                    error_count++;
                end
            end
        end
    end

    // remove on empty, extreme values, ties, then drain back to empty
    task automatic test_extremes_and_ties();
        send_request(KIND_REMOVE, '0);
        send_request(KIND_REMOVE, '1);
        send_request(KIND_INSERT, '0);
        send_request(KIND_INSERT, '1);
        send_request(KIND_INSERT, 16'h5555);
        send_request(KIND_INSERT, 16'hAAAA);
        send_request(KIND_INSERT, '1);
        send_request(KIND_INSERT, 16'h0007);
        send_request(KIND_INSERT, 16'h0007);
        send_request(KIND_INSERT, 16'h0007);
        send_request(KIND_INSERT, '0);
        repeat (9) send_request(KIND_REMOVE, 16'h1234);
        send_request(KIND_REMOVE, '0);
        start = 1'b0;
    endtask

    // top up to capacity, push past it, then remove from the full heap
    task automatic test_fill_to_full();
        repeat (CAPACITY - mirror_count) send_request(KIND_INSERT, VALUE_BITS'($urandom));
        send_request(KIND_INSERT, '1);
        send_request(KIND_INSERT, '0);
        send_request(KIND_REMOVE, '0);
        send_request(KIND_INSERT, VALUE_BITS'($urandom));
        repeat (40) send_request(KIND_REMOVE, VALUE_BITS'($urandom));
        start = 1'b0;
    endtask

    // mixed inserts and removes with a drifting bias so the fill level wanders
    task automatic test_random_mix(input int num_requests, input int idle_pct);
        int                    insert_pct;
        int                    pick;
        logic                  kind;
        logic [VALUE_BITS-1:0] value;
        sender_idle_pct = idle_pct;
        insert_pct      = 60;
        for (int n = 0; n < num_requests; n++) begin
            if (n % 50 == 0) begin
                insert_pct = $urandom_range(30, 75);
            end
            if (mirror_count == 0) begin
                kind = ($urandom_range(99) < 85) ? KIND_INSERT : KIND_REMOVE;
            end else begin
                kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            end
            // narrow value pools give plenty of ties
            pick = $urandom_range(99);
            if (pick < 50) begin
                value = VALUE_BITS'($urandom);
            end else if (pick < 75) begin
                value = VALUE_BITS'($urandom_range(0, 7));
            end else if (pick < 80) begin
                value = $urandom_range(1) ? '1 : '0;
            end else begin
                value = {8'($urandom), 8'h00};
            end
            send_request(kind, value);
        end
        start = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_kind          = KIND_INSERT;
        i_value         = '0;
        error_count     = 0;
        mirror_count    = 0;
        sender_idle_pct = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes_and_ties();
        test_random_mix(30, 0);
        test_random_mix(30, 52);
        test_random_mix(30, 8);
        sender_idle_pct = 8;
        test_fill_to_full();

        // let the last results drain, then allow a full walk of extra cycles
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * NUM_LEVELS + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
